[sv/sfcp_pkg.sv]
// Shared types and constants for the sensor frame checksum parser.
// No dependencies; compile first.
package sfcp_pkg;

    localparam int unsigned FRAME_LEN  = 11;
    localparam logic [3:0]  CHECK_POS  = 4'(FRAME_LEN - 1);
    localparam int unsigned HEADER_LEN = 4;

    localparam logic [7:0] HEADER_BYTES [0:HEADER_LEN-1] = '{8'h55, 8'h0A, 8'h85, 8'h01};

    localparam logic [3:0] COND_HI_POS = 4'd4;
    localparam logic [3:0] COND_LO_POS = 4'd5;
    localparam logic [3:0] TEMP_HI_POS = 4'd6;
    localparam logic [3:0] TEMP_LO_POS = 4'd7;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [15:0] DIV10_MULT  = 16'hCCCD;
    localparam int unsigned DIV10_SHIFT = 19;

    localparam int unsigned TEMP_W = 16;
    localparam int unsigned COND_W = 13;
    localparam int unsigned TDS_W  = 12;

    // One closed frame, handed from the front to the back
    typedef struct packed {
        logic        header_match;
        logic        sum_match;
        logic [15:0] cond_raw;
        logic [15:0] temp_raw;
    } frame_rec_t;

endpackage

[sv/sfcp_if.sv]
// Handshake channels of the sensor frame checksum parser: byte input, result output.
// Depends on nothing; compile after sfcp_pkg.
interface sfcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcp_result_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic        header_match;
    logic [15:0] temp_tenths;
    logic [12:0] conductivity;
    logic [11:0] tds_ppm;

    modport source (output valid, output frame_ok, output header_match,
                    output temp_tenths, output conductivity, output tds_ppm,
                    input ready);
    modport sink   (input valid, input frame_ok, input header_match,
                    input temp_tenths, input conductivity, input tds_ppm,
                    output ready);
endinterface

[sv/sensor_frame_checksum_parser.sv]
// A result turns valid once the eleventh byte of its frame has been accepted and its
// record has passed into the queue and then into the output register.
// Throughput: one byte per cycle, one result per 11-byte frame; the front stalls only
// when the frame queue is full on a closing byte, set by the output register drain rate.
// Reset (rst_n, async, active low): framing restarts at byte 0, held values clear to 0,
// queue and output register empty. No clearing pass; items accepted right after reset.
module sensor_frame_checksum_parser
    import sfcp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    sfcp_byte_if.sink     rx,
    sfcp_result_if.source res
);

    // Front side: framing, header compare, running sum and word capture
    // run per byte; a closed frame becomes one record in the queue.
    logic       push_valid;
    logic       push_ready;
    frame_rec_t push_rec;

    // Back side: divide and hold update run once per frame, so the
    // front keeps taking bytes while a result waits at the output.
    logic       pop_valid;
    logic       pop_ready;
    frame_rec_t pop_rec;

    sfcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    // Hold closed frames so the front waits on a slow result sink only
    // once the queue is full
    sfcp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    // Update held temperature, conductivity and dissolved solids on a good
    // frame; report every frame with the held values and status flags.
    sfcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_rec   (pop_rec),
        .res       (res)
    );

endmodule

[sv/sfcp_front.sv]
// Front end: counts bytes into frames, checks header and sum, captures words.
// Depends on sfcp_pkg and sfcp_byte_if.
module sfcp_front
    import sfcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sfcp_byte_if.sink   rx,
    output logic        push_valid,
    input  logic        push_ready,
    output frame_rec_t  push_rec
);

    logic [3:0]  pos_reg,    pos_next;
    logic [7:0]  sum_reg,    sum_next;
    logic        hdr_reg,    hdr_next;
    logic [15:0] cond_reg,   cond_next;
    logic [15:0] temp_reg,   temp_next;

    logic        at_check;
    logic        accept;

    assign at_check = (pos_reg >= CHECK_POS);
    assign rx.ready = !at_check || push_ready;
    assign accept   = rx.valid && rx.ready;

    assign push_valid            = rx.valid && at_check;
    assign push_rec.header_match = hdr_reg;
    assign push_rec.sum_match    = (sum_reg == rx.rx_byte);
    assign push_rec.cond_raw     = cond_reg;
    assign push_rec.temp_raw     = temp_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        hdr_next  = hdr_reg;
        cond_next = cond_reg;
        temp_next = temp_reg;
        if (accept)
        begin
            if (at_check)
            begin
                // close the frame
                pos_next = '0;
                sum_next = '0;
                hdr_next = 1'b1;
            end
            else
            begin
                if (pos_reg < 4'(HEADER_LEN) && rx.rx_byte != HEADER_BYTES[pos_reg[1:0]])
                begin
                    hdr_next = 1'b0;
                end
                sum_next = sum_reg + rx.rx_byte;
                pos_next = pos_reg + 4'd1;
                case (pos_reg)
                    COND_HI_POS: cond_next = {rx.rx_byte, cond_reg[7:0]};
                    COND_LO_POS: cond_next = {cond_reg[15:8], rx.rx_byte};
                    TEMP_HI_POS: temp_next = {rx.rx_byte, temp_reg[7:0]};
                    TEMP_LO_POS: temp_next = {temp_reg[15:8], rx.rx_byte};
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            hdr_reg  <= 1'b1;
            cond_reg <= '0;
            temp_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            hdr_reg  <= hdr_next;
            cond_reg <= cond_next;
            temp_reg <= temp_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= CHECK_POS)
        else $error("frame position out of range");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && at_check) |=> (pos_reg == 4'd0 && sum_reg == 8'd0 && hdr_reg))
        else $error("frame state not restarted after closing byte");
`endif

endmodule

[sv/sfcp_fifo.sv]
// Short queue of closed frame records between front and back.
// Depends on sfcp_pkg.
module sfcp_fifo
    import sfcp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  frame_rec_t  push_rec,
    output logic        pop_valid,
    input  logic        pop_ready,
    output frame_rec_t  pop_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t         mem [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
`endif

endmodule

[sv/sfcp_back.sv]
// Back end: applies a closed frame to the held values and registers the result.
// Depends on sfcp_pkg and sfcp_result_if.
module sfcp_back
    import sfcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  frame_rec_t    pop_rec,
    sfcp_result_if.source res
);

    logic               valid_reg,  valid_next;
    logic               ok_reg,     ok_next;
    logic               hdr_reg,    hdr_next;
    logic [TEMP_W-1:0]  temp_reg,   temp_next;
    logic [COND_W-1:0]  cond_reg,   cond_next;
    logic [TDS_W-1:0]   tds_reg,    tds_next;

    logic [31:0]        div_prod;
    logic [COND_W-1:0]  cond_div;
    logic               frame_ok;
    logic               do_pop;

    assign pop_ready = !valid_reg || res.ready;
    assign do_pop    = pop_valid && pop_ready;
    assign frame_ok  = pop_rec.header_match && pop_rec.sum_match;

    // conductivity word / 10 by reciprocal multiply
    assign div_prod = pop_rec.cond_raw * DIV10_MULT;
    assign cond_div = div_prod[DIV10_SHIFT +: COND_W];

    always_comb
    begin
        valid_next = valid_reg;
        ok_next    = ok_reg;
        hdr_next   = hdr_reg;
        temp_next  = temp_reg;
        cond_next  = cond_reg;
        tds_next   = tds_reg;
        if (res.valid && res.ready)
        begin
            valid_next = 1'b0;
        end
        if (do_pop)
        begin
            valid_next = 1'b1;
            ok_next    = frame_ok;
            hdr_next   = pop_rec.header_match;
            if (frame_ok)
            begin
                temp_next = pop_rec.temp_raw;
                cond_next = cond_div;
                tds_next  = cond_div[COND_W-1:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ok_reg    <= 1'b0;
            hdr_reg   <= 1'b0;
            temp_reg  <= '0;
            cond_reg  <= '0;
            tds_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ok_reg    <= ok_next;
            hdr_reg   <= hdr_next;
            temp_reg  <= temp_next;
            cond_reg  <= cond_next;
            tds_reg   <= tds_next;
        end
    end

    assign res.valid        = valid_reg;
    assign res.frame_ok     = ok_reg;
    assign res.header_match = hdr_reg;
    assign res.temp_tenths  = temp_reg;
    assign res.conductivity = cond_reg;
    assign res.tds_ppm      = tds_reg;

`ifndef SYNTHESIS
    a_ok_needs_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        ok_reg |-> hdr_reg)
        else $error("frame_ok set without header match");

    a_tds_half: assert property (@(posedge clk) disable iff (!rst_n)
        tds_reg == cond_reg[COND_W-1:1])
        else $error("held tds does not track held conductivity");

    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !frame_ok) |=> $stable(temp_reg) && $stable(cond_reg))
        else $error("held values changed on a failed frame");
`endif

endmodule
